/* rtl/mnps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mnps_pkg;

   // request command codes
   localparam logic [2:0] CMD_NOTE_ON    = 3'd0;
   localparam logic [2:0] CMD_LEGATO_ON  = 3'd1;
   localparam logic [2:0] CMD_NOTE_OFF   = 3'd2;
   localparam logic [2:0] CMD_ALL_OFF    = 3'd3;
   localparam logic [2:0] CMD_HOLD_CHECK = 3'd4;

   localparam int                KEY_W       = 7;
   localparam logic [KEY_W-1:0]  KEY_CENTER  = 7'd64;
   localparam logic signed [7:0] SILENT_KEY  = -8'sd1;
   localparam logic [13:0]       VEL_RESET   = 14'd12800;

   typedef enum logic [1:0] {
      CLS_DONE  = 2'd0,
      CLS_SHIFT = 2'd1,
      CLS_SCAN  = 2'd2
   } op_class_type;

   typedef struct packed {
      logic load;
      logic step_shift;
      logic step_scan;
      logic finish_shift;
      logic finish_scan;
   } dp_cmd_type;

   typedef struct packed {
      op_class_type cls;
      logic         pass_done;
   } dp_status_type;

   // (key - 64) * 128, the 7-bit wrap of the offset is exact over the key range
   function automatic logic signed [13:0] pitch_of(input logic [KEY_W-1:0] key);
      logic [KEY_W-1:0] offs;
      offs = key - KEY_CENTER;
      return $signed({offs, 7'b0});
   endfunction

endpackage

`default_nettype wire

/* rtl/mnps_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module mnps_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* rtl/mnps_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module mnps_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   output logic                        rsp_valid,
   output mnps_pkg::dp_cmd_type        dp_cmd,
   input  wire mnps_pkg::dp_status_type dp_status
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SHIFT = 3'b010,
      ST_SCAN  = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      dp_cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               dp_cmd.load = 1'b1;
               case (dp_status.cls)
                  mnps_pkg::CLS_SHIFT: state_in = ST_SHIFT;
                  mnps_pkg::CLS_SCAN:  state_in = ST_SCAN;
                  default:             rsp_valid_in = 1'b1;
               endcase
            end
         end
         ST_SHIFT: begin
            if (dp_status.pass_done) begin
               dp_cmd.finish_shift = 1'b1;
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end else begin
               dp_cmd.step_shift = 1'b1;
            end
         end
         ST_SCAN: begin
            if (dp_status.pass_done) begin
               dp_cmd.finish_scan = 1'b1;
               rsp_valid_in       = 1'b1;
               state_in           = ST_IDLE;
            end else begin
               dp_cmd.step_scan = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* rtl/mnps_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module mnps_datapath #(
   parameter int STACK_DEPTH = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire mnps_pkg::dp_cmd_type       dp_cmd,
   output mnps_pkg::dp_status_type         dp_status,
   input  wire logic [2:0]                 req_command,
   input  wire logic [6:0]                 req_note_key,
   input  wire logic [6:0]                 req_note_velocity,
   input  wire logic                       req_hold_pedal,
   output logic signed [13:0]              rsp_pitch_target,
   output logic        [13:0]              rsp_velocity_level,
   output logic                            rsp_gate,
   output logic signed [7:0]               rsp_sounding_key,
   output logic        [4:0]               rsp_stack_depth
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   // architectural state
   logic [CW-1:0]      count_ff, count_in;
   logic               gate_ff, gate_in;
   logic signed [7:0]  cur_key_ff, cur_key_in;
   logic signed [13:0] pitch_ff, pitch_in;
   logic [13:0]        vel_ff, vel_in;
   logic               rvalid_ff, rvalid_in;

   // pass bookkeeping
   logic [CW-1:0] rd_ff, rd_in;
   logic [CW-1:0] wr_ff, wr_in;
   logic [CW-1:0] lim_ff, lim_in;
   logic [6:0]    key_ff, key_in;
   logic          hold_ff, hold_in;
   logic          top_eq_ff, top_eq_in;
   logic [6:0]    last_kept_ff, last_kept_in;

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [6:0]    ram_wdata, ram_q;

   logic is_release, is_trigger, full, issue;

   mnps_ram #(
      .WIDTH (7),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   assign is_release = (req_command == mnps_pkg::CMD_NOTE_OFF) ||
                       ((req_command == mnps_pkg::CMD_NOTE_ON) && (req_note_velocity == '0));
   assign is_trigger = ((req_command == mnps_pkg::CMD_NOTE_ON) && (req_note_velocity != '0)) ||
                       (req_command == mnps_pkg::CMD_LEGATO_ON);
   assign full       = (count_ff == DEPTH_C);
   assign issue      = (dp_cmd.step_shift || dp_cmd.step_scan) && (rd_ff != lim_ff);

   always_comb begin
      if (is_release) begin
         dp_status.cls = mnps_pkg::CLS_SCAN;
      end else if (is_trigger && full) begin
         dp_status.cls = mnps_pkg::CLS_SHIFT;
      end else begin
         dp_status.cls = mnps_pkg::CLS_DONE;
      end
      dp_status.pass_done = (rd_ff == lim_ff) && !rvalid_ff;
   end

   always_comb begin
      count_in     = count_ff;
      gate_in      = gate_ff;
      cur_key_in   = cur_key_ff;
      pitch_in     = pitch_ff;
      vel_in       = vel_ff;
      rd_in        = rd_ff;
      wr_in        = wr_ff;
      lim_in       = lim_ff;
      key_in       = key_ff;
      hold_in      = hold_ff;
      top_eq_in    = top_eq_ff;
      last_kept_in = last_kept_ff;
      rvalid_in    = issue;
      ram_we       = 1'b0;
      ram_waddr    = wr_ff[AW-1:0];
      ram_wdata    = ram_q;
      ram_re       = issue;
      ram_raddr    = rd_ff[AW-1:0];

      if (dp_cmd.load) begin
         key_in    = req_note_key;
         hold_in   = req_hold_pedal;
         rd_in     = '0;
         wr_in     = '0;
         top_eq_in = 1'b1;
         if (is_release) begin
            cur_key_in = mnps_pkg::SILENT_KEY;
            lim_in     = count_ff;
         end else if (is_trigger) begin
            if ((req_command == mnps_pkg::CMD_NOTE_ON) && !gate_ff) begin
               vel_in = {req_note_velocity, 7'b0};
            end
            pitch_in   = mnps_pkg::pitch_of(req_note_key);
            cur_key_in = $signed({1'b0, req_note_key});
            gate_in    = 1'b1;
            if (full) begin
               // drop the oldest entry: move entries one place down
               rd_in  = ONE_C;
               lim_in = DEPTH_C;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = count_ff[AW-1:0];
               ram_wdata = req_note_key;
               count_in  = count_ff + ONE_C;
            end
         end else begin
            case (req_command)
               mnps_pkg::CMD_ALL_OFF: begin
                  cur_key_in = mnps_pkg::SILENT_KEY;
                  count_in   = '0;
                  gate_in    = 1'b0;
               end
               mnps_pkg::CMD_HOLD_CHECK: begin
                  if ((count_ff == '0) && !req_hold_pedal) begin
                     gate_in = 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end
      end

      if (issue) begin
         rd_in = rd_ff + ONE_C;
      end

      if (dp_cmd.step_shift && rvalid_ff) begin
         ram_we = 1'b1;
         wr_in  = wr_ff + ONE_C;
      end

      if (dp_cmd.step_scan && rvalid_ff) begin
         // entries arrive in order, so the last compare is the old top
         top_eq_in = (ram_q == key_ff);
         if (ram_q != key_ff) begin
            ram_we       = 1'b1;
            wr_in        = wr_ff + ONE_C;
            last_kept_in = ram_q;
         end
      end

      if (dp_cmd.finish_shift) begin
         ram_we    = 1'b1;
         ram_wdata = key_ff;
      end

      if (dp_cmd.finish_scan) begin
         count_in = wr_ff;
         if (top_eq_ff && (wr_ff != '0)) begin
            // released key was on top: retrigger the new top in place
            pitch_in   = mnps_pkg::pitch_of(last_kept_ff);
            cur_key_in = $signed({1'b0, last_kept_ff});
            gate_in    = 1'b1;
         end else if ((wr_ff == '0) && !hold_ff) begin
            gate_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         gate_ff    <= 1'b0;
         cur_key_ff <= mnps_pkg::SILENT_KEY;
         pitch_ff   <= '0;
         vel_ff     <= mnps_pkg::VEL_RESET;
         rvalid_ff  <= 1'b0;
      end else begin
         count_ff   <= count_in;
         gate_ff    <= gate_in;
         cur_key_ff <= cur_key_in;
         pitch_ff   <= pitch_in;
         vel_ff     <= vel_in;
         rvalid_ff  <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff        <= rd_in;
      wr_ff        <= wr_in;
      lim_ff       <= lim_in;
      key_ff       <= key_in;
      hold_ff      <= hold_in;
      top_eq_ff    <= top_eq_in;
      last_kept_ff <= last_kept_in;
   end

   assign rsp_pitch_target   = pitch_ff;
   assign rsp_velocity_level = vel_ff;
   assign rsp_gate           = gate_ff;
   assign rsp_sounding_key   = cur_key_ff;
   assign rsp_stack_depth    = 5'(count_ff);

endmodule

`default_nettype wire

/* rtl/mono_note_priority_stack_top.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel    ports                                              handshake
// request    req_command, req_note_key, req_note_velocity, ...  start high while busy is low
// response   rsp_pitch_target, rsp_velocity_level, rsp_gate, ...  rsp_valid for one cycle
//
// all off, hold check, unused codes and note on into a stack with room: strobe in the cycle
// after start. note off: one ram read per entry.
// note on into a full stack: each entry is moved down one place.
// a new request may be started in the cycle that carries the strobe.
// synchronous reset zeroes stack count, gate and pitch, sets key -1, velocity 12800; stack
// ram is never cleared, only entries below the count are read. the receiver cannot stall.

module mono_note_priority_stack_top #(
   parameter int STACK_DEPTH = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [2:0]         req_command,
   input  wire logic [6:0]         req_note_key,
   input  wire logic [6:0]         req_note_velocity,
   input  wire logic               req_hold_pedal,
   output logic                    rsp_valid,
   output logic signed [13:0]      rsp_pitch_target,
   output logic        [13:0]      rsp_velocity_level,
   output logic                    rsp_gate,
   output logic signed [7:0]       rsp_sounding_key,
   output logic        [4:0]       rsp_stack_depth
);

   mnps_pkg::dp_cmd_type    dp_cmd;
   mnps_pkg::dp_status_type dp_status;

   mnps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status)
   );

   mnps_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .dp_cmd             (dp_cmd),
      .dp_status          (dp_status),
      .req_command        (req_command),
      .req_note_key       (req_note_key),
      .req_note_velocity  (req_note_velocity),
      .req_hold_pedal     (req_hold_pedal),
      .rsp_pitch_target   (rsp_pitch_target),
      .rsp_velocity_level (rsp_velocity_level),
      .rsp_gate           (rsp_gate),
      .rsp_sounding_key   (rsp_sounding_key),
      .rsp_stack_depth    (rsp_stack_depth)
   );

endmodule

`default_nettype wire
